>>> sv/sfa_pkg.sv
package sfa_pkg;
    localparam int POSITION_BITS_DEF = 16;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_IP = 3'd1;
    localparam logic [2:0] ST_NOT_UDP = 3'd2;
    localparam logic [2:0] ST_BAD_VER = 3'd3;
    localparam logic [2:0] ST_BAD_ATYPE = 3'd4;
    localparam logic [2:0] ST_BAD_PROTO = 3'd5;

    typedef enum logic [4:0] {
        P_ETH, P_V4, P_V6, P_VER, P_ATYPE, P_NSAMP, P_SMP_TAG, P_SMP_LEN_FLOW,
        P_SMP_LEN_OTHER, P_FS_COUNT, P_REC_TAG, P_REC_LEN_RAW, P_REC_LEN_OTHER,
        P_RAW_PROTO, P_INNER_ETH, P_INNER_ZERO, P_REC_SKIP, P_SKIP_SAMPLE, P_DONE
    } t_stage;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] status;
    } t_out_item;
endpackage

>>> sv/sfa_if.sv
interface sfa_in_if;
    import sfa_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sfa_out_if;
    import sfa_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/sfa_parser.sv
module sfa_parser import sfa_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_item
);
    localparam int EW = POSITION_BITS + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] r_pos;
    t_stage r_stage;
    logic [31:0] r_acc, r_samples, r_records;
    logic [15:0] r_eth, r_ieth;
    logic [EW-1:0] r_hend, r_send, r_rend, r_istart;
    logic [2:0] r_fstat;

    logic [POSITION_BITS-1:0] n_pos;
    t_stage st;
    logic [31:0] n_acc, n_samples, n_records;
    logic [15:0] n_eth, n_ieth;
    logic [EW-1:0] n_hend, n_send, n_rend, n_istart, p, off;
    logic [2:0] n_fstat, status;
    logic zero;
    logic [7:0] b;
    logic [3:0] ihl;

    always_comb begin
        b = i_item.data;
        n_acc = {r_acc[23:0], b};
        p = {1'b0, r_pos};
        st = r_stage;
        n_pos = r_pos; n_eth = r_eth; n_ieth = r_ieth;
        n_samples = r_samples; n_records = r_records;
        n_hend = r_hend; n_send = r_send; n_rend = r_rend; n_istart = r_istart;
        n_fstat = r_fstat;
        zero = 1'b0;
        ihl = 4'd0;
        off = p - r_istart;
        if (r_pos != POS_MAX) begin
            if (r_eth == ETH_IPV4 && p >= EW'(26) && p <= EW'(33)) zero = 1'b1;
            if (r_eth == ETH_IPV6 && p >= EW'(22) && p <= EW'(53)) zero = 1'b1;
            if (st >= P_FS_COUNT && st <= P_SKIP_SAMPLE && p == r_send)
                st = (r_samples != 0) ? P_SMP_TAG : P_DONE;
            else if (st >= P_RAW_PROTO && st <= P_REC_SKIP && p == r_rend)
                st = (r_records != 0) ? P_REC_TAG : P_SKIP_SAMPLE;
            case (st)
                P_ETH: if (p == EW'(13)) begin
                    n_eth = n_acc[15:0];
                    if (n_acc[15:0] == ETH_IPV4) st = P_V4;
                    else if (n_acc[15:0] == ETH_IPV6) begin
                        n_hend = EW'(54); st = P_V6;
                    end else begin
                        if (n_fstat == ST_OK) n_fstat = ST_NOT_IP;
                        st = P_DONE;
                    end
                end
                P_V4: if (p == EW'(14)) begin
                    ihl = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
                    n_hend = EW'(14) + EW'({ihl, 2'b00});
                end else if (p == EW'(23)) begin
                    if (b == PROTO_UDP) st = P_VER;
                    else begin
                        if (n_fstat == ST_OK) n_fstat = ST_NOT_UDP;
                        st = P_DONE;
                    end
                end
                P_V6: if (p == EW'(20)) begin
                    if (b == PROTO_UDP) st = P_VER;
                    else begin
                        if (n_fstat == ST_OK) n_fstat = ST_NOT_UDP;
                        st = P_DONE;
                    end
                end
                P_VER: if (p == r_hend + EW'(11)) begin
                    if (n_acc == 32'd2 || n_acc == 32'd4 || n_acc == 32'd5) st = P_ATYPE;
                    else begin
                        if (n_fstat == ST_OK) n_fstat = ST_BAD_VER;
                        st = P_DONE;
                    end
                end
                P_ATYPE: if (p == r_hend + EW'(15)) begin
                    if (n_acc == 32'd1) begin
                        n_send = p + EW'(20); st = P_NSAMP;
                    end else if (n_acc == 32'd2) begin
                        n_send = p + EW'(32); st = P_NSAMP;
                    end else begin
                        if (n_fstat == ST_OK) n_fstat = ST_BAD_ATYPE;
                        st = P_DONE;
                    end
                end
                P_NSAMP: if (p == r_send) begin
                    n_samples = n_acc;
                    n_send = p + EW'(1);
                    st = (n_acc != 0) ? P_SMP_TAG : P_DONE;
                end
                P_SMP_TAG: if (p == r_send + EW'(3))
                    st = (n_acc[11:0] == 12'd1) ? P_SMP_LEN_FLOW : P_SMP_LEN_OTHER;
                P_SMP_LEN_FLOW, P_SMP_LEN_OTHER: if (p == r_send + EW'(7)) begin
                    n_samples = r_samples - 32'd1;
                    if (n_acc >= 32'(POS_MAX)) n_send = {1'b1, {POSITION_BITS{1'b0}}};
                    else n_send = p + EW'(1) + EW'(n_acc);
                    if (st == P_SMP_LEN_FLOW) begin
                        n_rend = p + EW'(33); st = P_FS_COUNT;
                    end else st = P_SKIP_SAMPLE;
                end
                P_FS_COUNT: if (p + EW'(1) == r_rend) begin
                    n_records = n_acc;
                    st = (n_acc != 0) ? P_REC_TAG : P_SKIP_SAMPLE;
                end
                P_REC_TAG: if (p == r_rend + EW'(3))
                    st = (n_acc[11:0] == 12'd1) ? P_REC_LEN_RAW : P_REC_LEN_OTHER;
                P_REC_LEN_RAW, P_REC_LEN_OTHER: if (p == r_rend + EW'(7)) begin
                    n_records = r_records - 32'd1;
                    if (n_acc >= 32'(POS_MAX)) n_rend = {1'b1, {POSITION_BITS{1'b0}}};
                    else n_rend = p + EW'(1) + EW'(n_acc);
                    if (st == P_REC_LEN_RAW) begin
                        n_istart = p + EW'(17); st = P_RAW_PROTO;
                    end else st = P_REC_SKIP;
                end
                P_RAW_PROTO: if (p + EW'(13) == r_istart) begin
                    if (n_acc == 32'd1) st = P_INNER_ETH;
                    else begin
                        if (n_fstat == ST_OK) n_fstat = ST_BAD_PROTO;
                        st = P_SKIP_SAMPLE;
                    end
                end
                P_INNER_ETH: if (p == r_istart + EW'(13)) begin
                    n_ieth = n_acc[15:0];
                    st = (n_acc[15:0] == ETH_IPV4 || n_acc[15:0] == ETH_IPV6)
                        ? P_INNER_ZERO : P_REC_SKIP;
                end
                P_INNER_ZERO: begin
                    if (r_ieth == ETH_IPV4) begin
                        if (off >= EW'(26) && off <= EW'(33)) zero = 1'b1;
                        if (off >= EW'(33)) st = P_REC_SKIP;
                    end else begin
                        if (off >= EW'(22) && off <= EW'(53)) zero = 1'b1;
                        if (off >= EW'(53)) st = P_REC_SKIP;
                    end
                end
                default: ;
            endcase
            n_pos = r_pos + 1'b1;
        end
        if (st == P_ETH) status = ST_NOT_IP;
        else if (st == P_V4 || st == P_V6) status = ST_NOT_UDP;
        else status = n_fstat;
        o_item.data = zero ? 8'd0 : b;
        o_item.last = i_item.last;
        o_item.status = i_item.last ? status : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last)) begin
            r_pos <= '0; r_stage <= P_ETH; r_acc <= '0; r_eth <= '0; r_ieth <= '0;
            r_samples <= '0; r_records <= '0; r_hend <= '0; r_send <= '0;
            r_rend <= '0; r_istart <= '0; r_fstat <= ST_OK;
        end else if (i_step) begin
            r_pos <= n_pos; r_stage <= st; r_acc <= n_acc; r_eth <= n_eth;
            r_ieth <= n_ieth; r_samples <= n_samples; r_records <= n_records;
            r_hend <= n_hend; r_send <= n_send; r_rend <= n_rend;
            r_istart <= n_istart; r_fstat <= n_fstat;
        end
    end
endmodule

>>> sv/sflow_address_anonymizer.sv
// Byte-serial sFlow address anonymizer: passes an Ethernet frame through one byte per
// transaction, zeroing outer and sampled-header IPv4/IPv6 addresses, with a status code
// on the last byte. One byte per cycle sustained while the output is not stalled; each
// byte is registered at the input, parsed by the position compare logic, and held in the
// output register, so a stalled output still lets one byte enter the input register.
module sflow_address_anonymizer import sfa_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sfa_in_if.sink    i_in,
    sfa_out_if.source o_out
);
    logic      r_in_valid, r_out_valid;
    t_in_item  r_in;
    t_out_item r_out, n_out;
    logic      step;

    assign step = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    sfa_parser #(.POSITION_BITS(POSITION_BITS)) u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_item(r_in), .o_item(n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (step) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
        if (i_in.ready && i_in.valid) r_in <= i_in.payload;
        if (step) r_out <= n_out;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid && $stable(o_out.payload))
        else $error("output changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.last) |-> o_out.payload.status == ST_OK)
        else $error("status on non-last byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out.valid)
        else $error("processed byte lost");
endmodule

>>> bench/sfa_checker.sv
module sfa_checker import sfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sfa_in_if    i_in,
    sfa_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);
    localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS_DEF) - 1;

    longint unsigned pos, hdr_end, smp_end, rec_end, inner_start;
    int unsigned     acc, smp_left, rec_left;
    logic [15:0]     eth_type, inner_type;
    t_stage          stage;
    logic [2:0]      frame_err;
    t_out_item       expected_bytes[$];

    function automatic void clear_parser();
        pos = 0;
        stage = P_ETH;
        acc = 0;
        eth_type = 0;
        hdr_end = 0;
        smp_left = 0;
        smp_end = 0;
        rec_left = 0;
        rec_end = 0;
        inner_start = 0;
        inner_type = 0;
        frame_err = ST_OK;
    endfunction

    function automatic void flag(input logic [2:0] code);
        if (frame_err == ST_OK) frame_err = code;
    endfunction

    function automatic t_out_item anonymize(input logic [7:0] b, input logic last);
        t_out_item       r;
        t_stage          st;
        logic            zero;
        longint unsigned p, off, lo, hi;
        int unsigned     w;
        logic [2:0]      code;
        p = pos;
        st = stage;
        zero = 1'b0;
        acc = (acc << 8) | b;
        w = acc;
        if (p < POS_LIMIT) begin
            if (eth_type == ETH_IPV4 && p >= 26 && p <= 33) zero = 1'b1;
            if (eth_type == ETH_IPV6 && p >= 22 && p <= 53) zero = 1'b1;
            if (st >= P_FS_COUNT && st <= P_SKIP_SAMPLE && p == smp_end)
                st = (smp_left != 0) ? P_SMP_TAG : P_DONE;
            else if (st >= P_RAW_PROTO && st <= P_REC_SKIP && p == rec_end)
                st = (rec_left != 0) ? P_REC_TAG : P_SKIP_SAMPLE;
            case (st)
                P_ETH: if (p == 13) begin
                    eth_type = w[15:0];
                    if (eth_type == ETH_IPV4) st = P_V4;
                    else if (eth_type == ETH_IPV6) begin
                        hdr_end = 54;
                        st = P_V6;
                    end else begin
                        flag(ST_NOT_IP);
                        st = P_DONE;
                    end
                end
                P_V4: begin
                    if (p == 14) hdr_end = 14 + 4 * ((b[3:0] < 5) ? 5 : b[3:0]);
                    else if (p == 23) begin
                        if (b == PROTO_UDP) st = P_VER;
                        else begin
                            flag(ST_NOT_UDP);
                            st = P_DONE;
                        end
                    end
                end
                P_V6: if (p == 20) begin
                    if (b == PROTO_UDP) st = P_VER;
                    else begin
                        flag(ST_NOT_UDP);
                        st = P_DONE;
                    end
                end
                P_VER: if (p == hdr_end + 11) begin
                    if (w == 2 || w == 4 || w == 5) st = P_ATYPE;
                    else begin
                        flag(ST_BAD_VER);
                        st = P_DONE;
                    end
                end
                P_ATYPE: if (p == hdr_end + 15) begin
                    if (w == 1) begin
                        smp_end = p + 20;
                        st = P_NSAMP;
                    end else if (w == 2) begin
                        smp_end = p + 32;
                        st = P_NSAMP;
                    end else begin
                        flag(ST_BAD_ATYPE);
                        st = P_DONE;
                    end
                end
                P_NSAMP: if (p == smp_end) begin
                    smp_left = w;
                    smp_end = p + 1;
                    st = (w != 0) ? P_SMP_TAG : P_DONE;
                end
                P_SMP_TAG: if (p == smp_end + 3)
                    st = (w[11:0] == 12'd1) ? P_SMP_LEN_FLOW : P_SMP_LEN_OTHER;
                P_SMP_LEN_FLOW, P_SMP_LEN_OTHER: if (p == smp_end + 7) begin
                    smp_left = smp_left - 1;
                    smp_end = p + 1 + longint'(w);
                    if (st == P_SMP_LEN_FLOW) begin
                        rec_end = p + 33;
                        st = P_FS_COUNT;
                    end else st = P_SKIP_SAMPLE;
                end
                P_FS_COUNT: if (p + 1 == rec_end) begin
                    rec_left = w;
                    st = (w != 0) ? P_REC_TAG : P_SKIP_SAMPLE;
                end
                P_REC_TAG: if (p == rec_end + 3)
                    st = (w[11:0] == 12'd1) ? P_REC_LEN_RAW : P_REC_LEN_OTHER;
                P_REC_LEN_RAW, P_REC_LEN_OTHER: if (p == rec_end + 7) begin
                    rec_left = rec_left - 1;
                    rec_end = p + 1 + longint'(w);
                    if (st == P_REC_LEN_RAW) begin
                        inner_start = p + 17;
                        st = P_RAW_PROTO;
                    end else st = P_REC_SKIP;
                end
                P_RAW_PROTO: if (p + 13 == inner_start) begin
                    if (w == 1) st = P_INNER_ETH;
                    else begin
                        flag(ST_BAD_PROTO);
                        st = P_SKIP_SAMPLE;
                    end
                end
                P_INNER_ETH: if (p == inner_start + 13) begin
                    inner_type = w[15:0];
                    st = (inner_type == ETH_IPV4 || inner_type == ETH_IPV6) ?
                         P_INNER_ZERO : P_REC_SKIP;
                end
                P_INNER_ZERO: begin
                    off = p - inner_start;
                    lo = (inner_type == ETH_IPV4) ? 26 : 22;
                    hi = (inner_type == ETH_IPV4) ? 33 : 53;
                    if (off >= lo && off <= hi) zero = 1'b1;
                    if (off >= hi) st = P_REC_SKIP;
                end
                default: ;
            endcase
            stage = st;
            pos = p + 1;
        end
        if (stage == P_ETH) code = ST_NOT_IP;
        else if (stage == P_V4 || stage == P_V6) code = ST_NOT_UDP;
        else code = frame_err;
        r.data = zero ? 8'd0 : b;
        r.last = last;
        r.status = last ? code : ST_OK;
        if (last) clear_parser();
        return r;
    endfunction

    assign o_pending = expected_bytes.size();

    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            clear_parser();
            expected_bytes.delete();
            o_errors <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = i_out.payload;
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected transaction %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data || got.last !== want.last ||
                        got.status !== want.status) begin
                        $display("%0t: mismatch data/last/status expected %h/%b/%0d got %h/%b/%0d",
                                 $time, want.data, want.last, want.status,
                                 got.data, got.last, got.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_bytes.push_back(anonymize(i_in.payload.data, i_in.payload.last));
        end
    end
endmodule

>>> bench/tb.sv
module tb;
    import sfa_pkg::*;

    logic i_clk, i_rst_n;
    int   errors, pending, sent, received, frames;
    int   cycles = 0;
    bit   no_idle, hold_done;
    byte unsigned frame[$];

    sfa_in_if  in_ch();
    sfa_out_if out_ch();

    sflow_address_anonymizer dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));
    sfa_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
                     .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 100000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void put_rand(input int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    function automatic void put32(input int unsigned v);
        for (int i = 3; i >= 0; i--) frame.push_back(v[8*i +: 8]);
    endfunction

    // length field: usually exact, sometimes off
    function automatic int unsigned len_field(input int n);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return $urandom;
        if (r == 1) return n + $urandom_range(0, 8);
        if (r == 2) return (n > 8) ? n - $urandom_range(1, 8) : 0;
        return n;
    endfunction

    function automatic void put_record();
        byte unsigned saved[$];
        int start, hlen;
        int r;
        saved = frame;
        frame.delete();
        r = $urandom_range(0, 9);
        put32(($urandom & 32'hffff_f000) | ((r < 8) ? 1 : $urandom_range(2, 4095)));
        start = 0;
        frame.delete();
        put32(($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1);
        put_rand(8);
        hlen = $urandom_range(14, 70);
        put32(hlen);
        put_rand(12);
        r = $urandom_range(0, 9);
        frame.push_back((r < 4) ? 8'h08 : (r < 8) ? 8'h86 : 8'($urandom));
        frame.push_back((r < 4) ? 8'h00 : (r < 8) ? 8'hdd : 8'($urandom));
        put_rand(hlen - 14);
        saved = {saved, 8'(0), 8'(0), 8'(0), 8'(0)};
        saved = saved[0:saved.size()-5];
        if ($urandom_range(0, 7) == 0) begin
            saved = {saved, 8'($urandom), 8'($urandom), 8'($urandom), 8'h02};
            frame = {frame};
        end else begin
            saved = {saved, 8'($urandom), 8'($urandom), 8'($urandom >> 4 << 4), 8'h01};
        end
        start = frame.size();
        begin
            byte unsigned body[$];
            body = frame;
            frame = saved;
            put32(len_field(start));
            frame = {frame, body};
        end
    endfunction

    function automatic void put_sample();
        byte unsigned saved[$], body[$];
        int nrec;
        saved = frame;
        frame.delete();
        if ($urandom_range(0, 4) != 0) begin
            put_rand(28);
            nrec = $urandom_range(0, 3);
            put32(($urandom_range(0, 15) == 0) ? $urandom_range(4, 9) : nrec);
            repeat (nrec) put_record();
            body = frame;
            frame = saved;
            put32(($urandom & 32'hffff_f000) | 1);
        end else begin
            put_rand($urandom_range(0, 20));
            body = frame;
            frame = saved;
            put32(($urandom & 32'hffff_f000) | $urandom_range(2, 4095));
        end
        put32(len_field(body.size()));
        frame = {frame, body};
    endfunction

    function automatic void build_frame(input int kind);
        int ihl, ns, r;
        frame.delete();
        put_rand(12);
        r = $urandom_range(0, 19);
        if (kind == 1 || (kind == 0 && r == 0)) begin
            put_rand($urandom_range(2, 40));
            return;
        end
        if (kind == 2 || (kind == 0 && r < 10)) begin
            frame.push_back(8'h08);
            frame.push_back(8'h00);
            ihl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 5;
            frame.push_back({4'($urandom), 4'(ihl)});
            put_rand(8);
            frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_UDP);
            put_rand(((ihl < 5) ? 20 : 4 * ihl) - 10);
        end else begin
            frame.push_back(8'h86);
            frame.push_back(8'hdd);
            put_rand(6);
            frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_UDP);
            put_rand(33);
        end
        put_rand(8);
        r = $urandom_range(0, 19);
        put32((r == 0) ? $urandom : (r < 3) ? 2 * r : 5);
        r = $urandom_range(0, 19);
        put32((r == 0) ? $urandom_range(3, 255) : (r < 10) ? 1 : 2);
        put_rand((r < 10) ? 16 : 28);
        ns = $urandom_range(0, 3);
        put32(($urandom_range(0, 15) == 0) ? ns + $urandom_range(1, 3) : ns);
        repeat (ns) put_sample();
        put_rand($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) frame = frame[0:$urandom_range(0, frame.size()-1)];
    endfunction

    task automatic send_frame();
        int gap;
        foreach (frame[i]) begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.payload <= '{data: frame[i], last: (i == frame.size() - 1)};
            do @(posedge i_clk); while (!in_ch.ready);
            sent++;
        end
        in_ch.valid <= 1'b0;
        frames++;
    endtask

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (received == 300 && !hold_done) begin
                hold_done = 1;
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            received++;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: single byte, two bytes, not IP, both address sizes
        frame = '{8'hff};
        send_frame();
        frame = '{8'h00, 8'h00};
        send_frame();
        for (int k = 0; k < 4; k++) begin
            build_frame(k < 2 ? 1 : 2 + (k & 1));
            send_frame();
        end
        wait (pending == 0);
        while (sent < 1600) begin
            build_frame(0);
            if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
            send_frame();
            if ($urandom_range(0, 30) == 0) wait (pending == 0);
        end
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes in %0d frames: IPv4/IPv6 sFlow, error paths, stalls.",
                 sent, frames);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
